### sv/pmes_pkg.sv
// pmes_pkg: shared types and constants for the pitch median/ema smoother
// no dependencies
package pmes_pkg;

  localparam int PITCH_WIDTH_DEF = 24;
  localparam int PITCH_OUT_W     = 24;
  localparam int CONF_W          = 16;
  localparam int CFG_DATA_W      = 16;
  localparam int CFG_IDX_W       = 1;
  localparam int HIST_DEPTH      = 5;
  localparam int SLOT_W          = 3;
  localparam int MED_RANK        = HIST_DEPTH / 2;
  localparam int Q16_SHIFT       = 16;
  localparam int Q16_HALF        = 32768;

  localparam logic [CONF_W-1:0] THRESHOLD_RST = 16'd55705;
  localparam logic [CONF_W-1:0] WEIGHT_RST    = 16'd9830;

  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_WEIGHT    = 1'b1;

  typedef logic [1:0] kind_t;
  localparam kind_t KIND_SHORT  = 2'd0;
  localparam kind_t KIND_RAW    = 2'd1;
  localparam kind_t KIND_SMOOTH = 2'd2;

  typedef struct packed {
    logic [PITCH_OUT_W-1:0] raw_frequency;
    logic [CONF_W-1:0]      raw_confidence;
    logic                   short_read;
  } in_item_t;

  typedef struct packed {
    logic [PITCH_OUT_W-1:0] pitch_out;
    logic [CONF_W-1:0]      confidence_out;
    logic                   was_smoothed;
  } out_item_t;

  typedef struct packed {
    kind_t             kind;
    logic [CONF_W-1:0] conf;
  } stage_info_t;

endpackage

### sv/pmes_stream_if.sv
// pmes_stream_if: valid/ready channel carrying one payload per transfer
// payload type supplied as a type parameter, usually from pmes_pkg
interface pmes_stream_if #(parameter type T = logic) ();
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

### sv/pmes_median.sv
// pmes_median: five-entry pitch history and median-of-five stage
// depends on pmes_pkg
module pmes_median #(
  parameter int PITCH_WIDTH = pmes_pkg::PITCH_WIDTH_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     s1_valid,
  output logic                     s1_ready,
  input  pmes_pkg::stage_info_t    s1_info,
  input  logic [PITCH_WIDTH-1:0]   s1_freq,
  output logic                     s2_valid,
  input  logic                     s2_ready,
  output pmes_pkg::stage_info_t    s2_info,
  output logic [PITCH_WIDTH-1:0]   s2_pitch
);

  localparam int DEPTH  = pmes_pkg::HIST_DEPTH;
  localparam int SLOT_W = pmes_pkg::SLOT_W;

  logic [PITCH_WIDTH-1:0] hist_r [DEPTH];
  logic [SLOT_W-1:0]      slot_r;
  logic [SLOT_W-1:0]      slot_nxt;
  logic [PITCH_WIDTH-1:0] cand [DEPTH];
  logic [PITCH_WIDTH-1:0] med;
  logic                   s1_fire;
  logic                   s1_smooth;

  logic                   s2_valid_r;
  pmes_pkg::stage_info_t  s2_info_r;
  logic [PITCH_WIDTH-1:0] s2_pitch_r;

  assign s1_ready  = !s2_valid_r || s2_ready;
  assign s1_fire   = s1_valid && s1_ready;
  assign s1_smooth = (s1_info.kind == pmes_pkg::KIND_SMOOTH);
  assign slot_nxt  = (slot_r == SLOT_W'(DEPTH - 1)) ? '0 : slot_r + SLOT_W'(1);

  // history as it stands after this write
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      cand[i] = (slot_r == SLOT_W'(i)) ? s1_freq : hist_r[i];
    end
  end

  // rank each entry, ties broken by position; the middle rank is the median
  always_comb begin
    logic [DEPTH-1:0] below;
    logic [SLOT_W-1:0] rank;
    med = '0;
    for (int i = 0; i < DEPTH; i++) begin
      for (int j = 0; j < DEPTH; j++) begin
        below[j] = (j != i) &&
                   ((cand[j] < cand[i]) || ((cand[j] == cand[i]) && (j < i)));
      end
      rank = SLOT_W'($countones(below));
      if (rank == SLOT_W'(pmes_pkg::MED_RANK)) begin
        med = med | cand[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_r <= '0;
      for (int i = 0; i < DEPTH; i++) begin
        hist_r[i] <= '0;
      end
    end else if (s1_fire && s1_smooth) begin
      hist_r[slot_r] <= s1_freq;
      slot_r         <= slot_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (s1_ready) begin
      s2_valid_r <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      s2_info_r  <= s1_info;
      s2_pitch_r <= s1_smooth ? med : s1_freq;
    end
  end

  assign s2_valid = s2_valid_r;
  assign s2_info  = s2_info_r;
  assign s2_pitch = s2_pitch_r;

  a_slot_range: assert property (@(posedge clk) disable iff (!rst_n)
    slot_r <= SLOT_W'(DEPTH - 1))
    else $error("history slot out of range");

  a_slot_advance: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_fire && s1_smooth) |=>
      (slot_r == (($past(slot_r) == SLOT_W'(DEPTH - 1)) ? '0 : $past(slot_r) + SLOT_W'(1))))
    else $error("history slot did not advance");

  a_slot_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_fire && !s1_smooth) |=> $stable(slot_r))
    else $error("history slot moved on a bypass item");

endmodule

### sv/pmes_ema_unit.sv
// pmes_ema_unit: one rounded q0.16 moving-average step, old + alpha*(x - old)
// depends on pmes_pkg
module pmes_ema_unit #(
  parameter int W = pmes_pkg::PITCH_WIDTH_DEF
) (
  input  logic [W-1:0]                x,
  input  logic [W-1:0]                old,
  input  logic [pmes_pkg::CONF_W-1:0] alpha,
  output logic [W-1:0]                avg
);

  localparam int PW = W + pmes_pkg::CONF_W + 2;
  localparam int SH = pmes_pkg::Q16_SHIFT;

  logic signed [W:0]    diff;
  logic signed [PW-1:0] prod;
  logic signed [PW-1:0] rnd;
  logic signed [W+1:0]  step;
  logic signed [W+1:0]  sum;

  assign diff = $signed({1'b0, x}) - $signed({1'b0, old});
  assign prod = PW'(diff) * PW'($signed({1'b0, alpha}));
  assign rnd  = prod + $signed(PW'(pmes_pkg::Q16_HALF));
  assign step = rnd[PW-1:SH];
  assign sum  = $signed({2'b00, old}) + step;
  assign avg  = sum[W-1:0];

endmodule

### sv/pmes_smooth.sv
// pmes_smooth: moving-average state, seeding and the result register
// depends on pmes_pkg, pmes_stream_if and pmes_ema_unit
module pmes_smooth #(
  parameter int PITCH_WIDTH = pmes_pkg::PITCH_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [pmes_pkg::CONF_W-1:0]   weight,
  input  logic                          s2_valid,
  output logic                          s2_ready,
  input  pmes_pkg::stage_info_t         s2_info,
  input  logic [PITCH_WIDTH-1:0]        s2_pitch,
  pmes_stream_if.source                 out_item
);

  localparam int CW = pmes_pkg::CONF_W;
  localparam int OW = pmes_pkg::PITCH_OUT_W;

  logic                   seeded_r;
  logic [PITCH_WIDTH-1:0] sm_pitch_r;
  logic [PITCH_WIDTH-1:0] sm_pitch_nxt;
  logic [CW-1:0]          sm_conf_r;
  logic [CW-1:0]          sm_conf_nxt;
  logic [PITCH_WIDTH-1:0] ema_pitch;
  logic [CW-1:0]          ema_conf;
  logic                   out_valid_r;
  pmes_pkg::out_item_t    out_r;
  pmes_pkg::out_item_t    out_nxt;
  logic                   s2_fire;
  logic                   s2_smooth;

  assign s2_ready  = !out_valid_r || out_item.ready;
  assign s2_fire   = s2_valid && s2_ready;
  assign s2_smooth = (s2_info.kind == pmes_pkg::KIND_SMOOTH);

  pmes_ema_unit #(.W(PITCH_WIDTH)) u_ema_pitch (
    .x     (s2_pitch),
    .old   (sm_pitch_r),
    .alpha (weight),
    .avg   (ema_pitch)
  );

  pmes_ema_unit #(.W(CW)) u_ema_conf (
    .x     (s2_info.conf),
    .old   (sm_conf_r),
    .alpha (weight),
    .avg   (ema_conf)
  );

  assign sm_pitch_nxt = seeded_r ? ema_pitch : s2_pitch;
  assign sm_conf_nxt  = seeded_r ? ema_conf : s2_info.conf;

  always_comb begin
    out_nxt = '0;
    case (s2_info.kind)
      pmes_pkg::KIND_RAW: begin
        out_nxt.pitch_out      = OW'(s2_pitch);
        out_nxt.confidence_out = s2_info.conf;
      end
      pmes_pkg::KIND_SMOOTH: begin
        out_nxt.pitch_out      = OW'(sm_pitch_nxt);
        out_nxt.confidence_out = sm_conf_nxt;
        out_nxt.was_smoothed   = 1'b1;
      end
      default: begin
        out_nxt = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seeded_r   <= 1'b0;
      sm_pitch_r <= '0;
      sm_conf_r  <= '0;
    end else if (s2_fire && s2_smooth) begin
      seeded_r   <= 1'b1;
      sm_pitch_r <= sm_pitch_nxt;
      sm_conf_r  <= sm_conf_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s2_ready) begin
      out_valid_r <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_fire) begin
      out_r <= out_nxt;
    end
  end

  assign out_item.valid = out_valid_r;
  assign out_item.data  = out_r;

  a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (s2_fire && !s2_smooth) |=> ($stable(sm_pitch_r) && $stable(sm_conf_r)))
    else $error("average changed on a bypass item");

  a_ema_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (s2_fire && s2_smooth && seeded_r) |=>
      (sm_pitch_r <= (($past(s2_pitch) > $past(sm_pitch_r)) ?
                      $past(s2_pitch) : $past(sm_pitch_r))))
    else $error("pitch average exceeds its inputs");

  a_smoothed_seeded: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.was_smoothed) |-> seeded_r)
    else $error("smoothed result without a seeded average");

endmodule

### sv/pitch_median_ema_smoother_top.sv
// pitch_median_ema_smoother_top: input register, config registers, median and average stages
// depends on pmes_pkg, pmes_stream_if, pmes_median, pmes_smooth
// path: input, median and result registers lie between an input transfer and its result valid
// throughput: one item per cycle while the output is not stalled; the average feedback closes in the result stage
// reset: history, slot, averages and seed flag cleared; threshold and weight return to defaults
module pitch_median_ema_smoother_top #(
  parameter int PITCH_WIDTH = pmes_pkg::PITCH_WIDTH_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic [pmes_pkg::CFG_IDX_W-1:0]     cfg_idx,
  input  logic [pmes_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  pmes_stream_if.sink                        in_item,
  pmes_stream_if.source                      out_item
);

  localparam int CW = pmes_pkg::CONF_W;

  logic [CW-1:0]          threshold_r;
  logic [CW-1:0]          weight_r;

  logic                   s1_valid_r;
  pmes_pkg::stage_info_t  s1_info_r;
  pmes_pkg::stage_info_t  s1_info_nxt;
  logic [PITCH_WIDTH-1:0] s1_freq_r;
  logic                   s1_ready;
  logic                   in_fire;

  logic                   s2_valid;
  logic                   s2_ready;
  pmes_pkg::stage_info_t  s2_info;
  logic [PITCH_WIDTH-1:0] s2_pitch;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      threshold_r <= pmes_pkg::THRESHOLD_RST;
      weight_r    <= pmes_pkg::WEIGHT_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        pmes_pkg::REG_THRESHOLD: threshold_r <= CW'(cfg_wdata);
        pmes_pkg::REG_WEIGHT:    weight_r    <= CW'(cfg_wdata);
      endcase
    end
  end

  assign in_item.ready = !s1_valid_r || s1_ready;
  assign in_fire       = in_item.valid && in_item.ready;

  // classify at the input: short read, low-confidence bypass or smoothed
  always_comb begin
    s1_info_nxt.conf = in_item.data.raw_confidence;
    if (in_item.data.short_read) begin
      s1_info_nxt.kind = pmes_pkg::KIND_SHORT;
    end else if (in_item.data.raw_confidence < threshold_r) begin
      s1_info_nxt.kind = pmes_pkg::KIND_RAW;
    end else begin
      s1_info_nxt.kind = pmes_pkg::KIND_SMOOTH;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_item.ready) begin
      s1_valid_r <= in_item.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_info_r <= s1_info_nxt;
      s1_freq_r <= PITCH_WIDTH'(in_item.data.raw_frequency);
    end
  end

  pmes_median #(.PITCH_WIDTH(PITCH_WIDTH)) u_median (
    .clk      (clk),
    .rst_n    (rst_n),
    .s1_valid (s1_valid_r),
    .s1_ready (s1_ready),
    .s1_info  (s1_info_r),
    .s1_freq  (s1_freq_r),
    .s2_valid (s2_valid),
    .s2_ready (s2_ready),
    .s2_info  (s2_info),
    .s2_pitch (s2_pitch)
  );

  pmes_smooth #(.PITCH_WIDTH(PITCH_WIDTH)) u_smooth (
    .clk      (clk),
    .rst_n    (rst_n),
    .weight   (weight_r),
    .s2_valid (s2_valid),
    .s2_ready (s2_ready),
    .s2_info  (s2_info),
    .s2_pitch (s2_pitch),
    .out_item (out_item)
  );

endmodule
